@@ src/ray_box_intersection_unit_assert.svh @@
// Assertion macros used by the checker of the ray box unit.
// Both expect signals named clk and arst_n in the scope where they are used.
`ifndef RAY_BOX_INTERSECTION_UNIT_ASSERT_SVH
`define RAY_BOX_INTERSECTION_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RBI_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ray box check failed");

// The consequent must hold in the cycle after the antecedent.
`define RBI_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ray box check failed");

`endif

@@ src/rbi_pkg.sv @@
package rbi_pkg;

	localparam int COORD_W = 32;
	localparam int DIFF_W = 33;
	localparam int T_W = 64;
	localparam int FRAC_BITS_DEF = 16;
	localparam int PT_STAGES = 5;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic signed [T_W-1:0] param_t;

	localparam coord_t COORD_MAX = 32'sh7FFF_FFFF;
	localparam coord_t COORD_MIN = 32'sh8000_0000;
	localparam param_t T_INF = 64'sh4000_0000_0000_0000;

	typedef struct packed {
		coord_t box_min_x;
		coord_t box_min_y;
		coord_t box_min_z;
		coord_t box_max_x;
		coord_t box_max_y;
		coord_t box_max_z;
		coord_t start_x;
		coord_t start_y;
		coord_t start_z;
		coord_t end_x;
		coord_t end_y;
		coord_t end_z;
	} rbi_in_t;

	typedef struct packed {
		logic hit;
		coord_t point_x;
		coord_t point_y;
		coord_t point_z;
	} rbi_out_t;

	typedef struct packed {
		logic [2:0][COORD_W-1:0] f;
		logic [2:0][DIFF_W-1:0] d;
		logic [2:0] sgn_n;
		logic [2:0] sgn_x;
		logic [2:0] dz;
		logic [2:0] ok;
		logic allz;
	} rbi_side_t;

endpackage

@@ src/rbi_delay.sv @@
module rbi_delay #(
	parameter int W = 1,
	parameter int D = 1
) (
	input logic clk,
	input logic en,
	input logic [W-1:0] din,
	output logic [W-1:0] dout
);

	logic [W-1:0] dly_sk [D];

	always_ff @(posedge clk) begin
		if (en) begin
			dly_sk[0] <= din;
			for (int k = 1; k < D; k++) begin
				dly_sk[k] <= dly_sk[k-1];
			end
		end
	end

	assign dout = dly_sk[D-1];

endmodule

@@ src/rbi_div.sv @@
// Unsigned restoring divider, one quotient bit per register stage.
module rbi_div #(
	parameter int NW = 49,
	parameter int DW = 33
) (
	input logic clk,
	input logic en,
	input logic [NW-1:0] num,
	input logic [DW-1:0] den,
	output logic [NW-1:0] quo
);

	logic [DW-1:0] rem_sk [NW-1];
	logic [DW-1:0] den_sk [NW-1];
	logic [NW-1:0] sh_sk [NW];

	for (genvar i = 0; i < NW; i++) begin : g_st
		logic [DW-1:0] r_in;
		logic [DW-1:0] b_in;
		logic [NW-1:0] s_in;
		logic [DW:0] trial;
		logic ge;

		if (i == 0) begin : g_first
			assign r_in = '0;
			assign b_in = den;
			assign s_in = num;
		end else begin : g_next
			assign r_in = rem_sk[i-1];
			assign b_in = den_sk[i-1];
			assign s_in = sh_sk[i-1];
		end

		assign trial = {r_in, s_in[NW-1]};
		assign ge = trial >= {1'b0, b_in};

		always_ff @(posedge clk) begin
			if (en) begin
				sh_sk[i] <= {s_in[NW-2:0], ge};
			end
		end

		if (i < NW - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_sk[i] <= ge ? DW'(trial - {1'b0, b_in}) : trial[DW-1:0];
					den_sk[i] <= b_in;
				end
			end
		end
	end

	assign quo = sh_sk[NW-1];

endmodule

@@ src/rbi_point.sv @@
// Entry point on one axis: start plus direction times parameter, saturated.
module rbi_point #(
	parameter int FRAC_BITS = rbi_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic en,
	input rbi_pkg::coord_t f,
	input rbi_pkg::diff_t d,
	input rbi_pkg::param_t t,
	output rbi_pkg::coord_t point
);

	localparam int DIFF_W = rbi_pkg::DIFF_W;
	localparam int T_W = rbi_pkg::T_W;
	localparam int NW = DIFF_W + FRAC_BITS;
	localparam int HW = (NW + 1) / 2;
	localparam int LW = NW - HW;
	localparam int PLW = DIFF_W + HW;
	localparam int PHW = DIFF_W + LW;
	localparam int PW = DIFF_W + NW;

	logic [DIFF_W-1:0] ad_s1;
	logic [NW-1:0] at_s1;
	logic byp_s1, neg_s1;
	rbi_pkg::coord_t f_s1;

	logic [PLW-1:0] plo_s2;
	logic [PHW-1:0] phi_s2;
	logic byp_s2, neg_s2;
	rbi_pkg::coord_t f_s2;

	logic [PW-1:0] prod_s3;
	logic byp_s3, neg_s3;
	rbi_pkg::coord_t f_s3;

	rbi_pkg::param_t sum_s4;
	logic ovf_s4, byp_s4, neg_s4;
	rbi_pkg::coord_t f_s4;

	rbi_pkg::coord_t point_s5;

	rbi_pkg::param_t t_abs;
	rbi_pkg::param_t m64;
	rbi_pkg::param_t f64;
	rbi_pkg::coord_t res;

	assign t_abs = t[T_W-1] ? -t : t;
	assign m64 = T_W'(prod_s3 >> FRAC_BITS);
	assign f64 = rbi_pkg::param_t'(f_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			ad_s1 <= d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
			at_s1 <= t_abs[NW-1:0];
			byp_s1 <= (d == '0) || (t == '0);
			neg_s1 <= d[DIFF_W-1] ^ t[T_W-1];
			f_s1 <= f;

			plo_s2 <= PLW'(ad_s1) * PLW'(at_s1[HW-1:0]);
			phi_s2 <= PHW'(ad_s1) * PHW'(at_s1[NW-1:HW]);
			byp_s2 <= byp_s1;
			neg_s2 <= neg_s1;
			f_s2 <= f_s1;

			prod_s3 <= PW'(plo_s2) + (PW'(phi_s2) << HW);
			byp_s3 <= byp_s2;
			neg_s3 <= neg_s2;
			f_s3 <= f_s2;

			ovf_s4 <= prod_s3 > (PW'(1) << 62);
			sum_s4 <= neg_s3 ? f64 - m64 : f64 + m64;
			byp_s4 <= byp_s3;
			neg_s4 <= neg_s3;
			f_s4 <= f_s3;

			point_s5 <= res;
		end
	end

	always_comb begin
		if (byp_s4) begin
			res = f_s4;
		end else if (ovf_s4) begin
			res = neg_s4 ? rbi_pkg::COORD_MIN : rbi_pkg::COORD_MAX;
		end else if (sum_s4 > rbi_pkg::param_t'(rbi_pkg::COORD_MAX)) begin
			res = rbi_pkg::COORD_MAX;
		end else if (sum_s4 < rbi_pkg::param_t'(rbi_pkg::COORD_MIN)) begin
			res = rbi_pkg::COORD_MIN;
		end else begin
			res = sum_s4[rbi_pkg::COORD_W-1:0];
		end
	end

	assign point = point_s5;

endmodule

@@ src/ray_box_intersection_unit.sv @@
// Channel  Handshake             Payload               Transaction
// ray      ray_valid/ray_ready   ray (rbi_in_t)        one box and segment
// res      res_valid/res_ready   res (rbi_out_t)       hit flag and entry point
//
// One transaction per cycle while ray_ready is high; the pipeline has two front stages,
// one divider stage per quotient bit, three slab merge stages and five point stages.
// Reset clears the stage valid bits and the output skid flag.
// A stalled result moves into a skid register while the pipeline still advances in
// that cycle; ray_ready then drops until that result is taken.
module ray_box_intersection_unit #(
	parameter int FRAC_BITS = rbi_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic ray_valid,
	output logic ray_ready,
	input rbi_pkg::rbi_in_t ray,
	output logic res_valid,
	input logic res_ready,
	output rbi_pkg::rbi_out_t res
);

	localparam int DIFF_W = rbi_pkg::DIFF_W;
	localparam int COORD_W = rbi_pkg::COORD_W;
	localparam int T_W = rbi_pkg::T_W;
	localparam int NW = DIFF_W + FRAC_BITS;
	localparam int N = NW + 5 + rbi_pkg::PT_STAGES;
	localparam int SIDE_W = $bits(rbi_pkg::rbi_side_t);

	logic en;
	logic [N-1:0] v_q;
	logic skid_full_q;
	rbi_pkg::rbi_out_t skid_q;
	rbi_pkg::rbi_out_t last;

	rbi_pkg::coord_t lo [3];
	rbi_pkg::coord_t hi [3];
	rbi_pkg::coord_t st [3];
	rbi_pkg::coord_t ed [3];

	rbi_pkg::diff_t d_s1 [3];
	rbi_pkg::diff_t nlo_s1 [3];
	rbi_pkg::diff_t nhi_s1 [3];
	rbi_pkg::coord_t f_s1 [3];

	logic [DIFF_W-1:0] magn [3];
	logic [DIFF_W-1:0] magx [3];
	logic [DIFF_W-1:0] dmag [3];
	rbi_pkg::rbi_side_t side;

	logic [DIFF_W-1:0] magn_s2 [3];
	logic [DIFF_W-1:0] magx_s2 [3];
	logic [DIFF_W-1:0] dmag_s2 [3];
	rbi_pkg::rbi_side_t side_s2;

	logic [NW-1:0] qn [3];
	logic [NW-1:0] qx [3];
	rbi_pkg::rbi_side_t side_dly;

	rbi_pkg::param_t tn [3];
	rbi_pkg::param_t tx [3];
	rbi_pkg::param_t tn_s3 [3];
	rbi_pkg::param_t tx_s3 [3];
	logic hit_s3;
	logic [2:1] ok_s3;
	rbi_pkg::coord_t f_s3 [3];
	rbi_pkg::diff_t d_s3 [3];

	rbi_pkg::param_t tmin_s4, tmax_s4, tnz_s4, txz_s4;
	logic hit_s4, okz_s4;
	rbi_pkg::coord_t f_s4 [3];
	rbi_pkg::diff_t d_s4 [3];

	rbi_pkg::param_t tmin_s5;
	logic hit_s5;
	rbi_pkg::coord_t f_s5 [3];
	rbi_pkg::diff_t d_s5 [3];

	rbi_pkg::coord_t point [3];
	logic hit_out;

	assign en = !skid_full_q;
	assign ray_ready = en;

	always_comb begin
		lo[0] = ray.box_min_x;
		lo[1] = ray.box_min_y;
		lo[2] = ray.box_min_z;
		hi[0] = ray.box_max_x;
		hi[1] = ray.box_max_y;
		hi[2] = ray.box_max_z;
		st[0] = ray.start_x;
		st[1] = ray.start_y;
		st[2] = ray.start_z;
		ed[0] = ray.end_x;
		ed[1] = ray.end_y;
		ed[2] = ray.end_z;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				d_s1[a] <= rbi_pkg::diff_t'(ed[a]) - rbi_pkg::diff_t'(st[a]);
				nlo_s1[a] <= rbi_pkg::diff_t'(lo[a]) - rbi_pkg::diff_t'(st[a]);
				nhi_s1[a] <= rbi_pkg::diff_t'(hi[a]) - rbi_pkg::diff_t'(st[a]);
				f_s1[a] <= st[a];
			end
		end
	end

	// The divisor's sign picks which bound gives the entry parameter.
	always_comb begin
		rbi_pkg::diff_t nn;
		rbi_pkg::diff_t nx;
		logic dneg;
		logic dz;
		side = '0;
		for (int a = 0; a < 3; a++) begin
			dneg = d_s1[a][DIFF_W-1];
			dz = d_s1[a] == '0;
			nn = dneg ? nhi_s1[a] : nlo_s1[a];
			nx = dneg ? nlo_s1[a] : nhi_s1[a];
			magn[a] = nn[DIFF_W-1] ? DIFF_W'(-nn) : DIFF_W'(nn);
			magx[a] = nx[DIFF_W-1] ? DIFF_W'(-nx) : DIFF_W'(nx);
			dmag[a] = dneg ? DIFF_W'(-d_s1[a]) : DIFF_W'(d_s1[a]);
			side.f[a] = f_s1[a];
			side.d[a] = d_s1[a];
			side.sgn_n[a] = nn[DIFF_W-1] ^ dneg;
			side.sgn_x[a] = nx[DIFF_W-1] ^ dneg;
			side.dz[a] = dz;
			side.ok[a] = !dz || (nlo_s1[a][DIFF_W-1] || nlo_s1[a] == '0)
				&& !nhi_s1[a][DIFF_W-1];
		end
		side.allz = &side.dz;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			magn_s2 <= magn;
			magx_s2 <= magx;
			dmag_s2 <= dmag;
			side_s2 <= side;
		end
	end

	for (genvar a = 0; a < 3; a++) begin : g_ax
		rbi_div #(
			.NW(NW),
			.DW(DIFF_W)
		) u_div_n (
			.clk(clk),
			.en(en),
			.num({magn_s2[a], {FRAC_BITS{1'b0}}}),
			.den(dmag_s2[a]),
			.quo(qn[a])
		);

		rbi_div #(
			.NW(NW),
			.DW(DIFF_W)
		) u_div_x (
			.clk(clk),
			.en(en),
			.num({magx_s2[a], {FRAC_BITS{1'b0}}}),
			.den(dmag_s2[a]),
			.quo(qx[a])
		);
	end

	rbi_delay #(
		.W(SIDE_W),
		.D(NW)
	) u_side_dly (
		.clk(clk),
		.en(en),
		.din(side_s2),
		.dout(side_dly)
	);

	always_comb begin
		rbi_pkg::param_t qne;
		rbi_pkg::param_t qxe;
		for (int a = 0; a < 3; a++) begin
			qne = T_W'(qn[a]);
			qxe = T_W'(qx[a]);
			if (side_dly.dz[a]) begin
				tn[a] = -rbi_pkg::T_INF;
				tx[a] = rbi_pkg::T_INF;
			end else begin
				tn[a] = side_dly.sgn_n[a] ? -qne : qne;
				tx[a] = side_dly.sgn_x[a] ? -qxe : qxe;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				tn_s3[a] <= tn[a];
				tx_s3[a] <= tx[a];
				f_s3[a] <= side_dly.f[a];
				d_s3[a] <= side_dly.d[a];
			end
			hit_s3 <= !side_dly.allz && side_dly.ok[0];
			ok_s3 <= side_dly.ok[2:1];

			hit_s4 <= hit_s3 && ok_s3[1] && !(tn_s3[0] > tx_s3[1]) && !(tn_s3[1] > tx_s3[0]);
			tmin_s4 <= (tn_s3[1] > tn_s3[0]) ? tn_s3[1] : tn_s3[0];
			tmax_s4 <= (tx_s3[1] < tx_s3[0]) ? tx_s3[1] : tx_s3[0];
			tnz_s4 <= tn_s3[2];
			txz_s4 <= tx_s3[2];
			okz_s4 <= ok_s3[2];
			f_s4 <= f_s3;
			d_s4 <= d_s3;

			hit_s5 <= hit_s4 && okz_s4 && !(tmin_s4 > txz_s4) && !(tnz_s4 > tmax_s4);
			tmin_s5 <= (tnz_s4 > tmin_s4) ? tnz_s4 : tmin_s4;
			f_s5 <= f_s4;
			d_s5 <= d_s4;
		end
	end

	for (genvar a = 0; a < 3; a++) begin : g_pt
		rbi_point #(
			.FRAC_BITS(FRAC_BITS)
		) u_point (
			.clk(clk),
			.en(en),
			.f(f_s5[a]),
			.d(d_s5[a]),
			.t(tmin_s5),
			.point(point[a])
		);
	end

	rbi_delay #(
		.W(1),
		.D(rbi_pkg::PT_STAGES)
	) u_hit_dly (
		.clk(clk),
		.en(en),
		.din(hit_s5),
		.dout(hit_out)
	);

	always_comb begin
		last.hit = hit_out;
		last.point_x = hit_out ? point[0] : COORD_W'(0);
		last.point_y = hit_out ? point[1] : COORD_W'(0);
		last.point_z = hit_out ? point[2] : COORD_W'(0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
			skid_full_q <= 1'b0;
		end else begin
			if (en) begin
				v_q <= {v_q[N-2:0], ray_valid};
			end
			if (skid_full_q) begin
				if (res_ready) begin
					skid_full_q <= 1'b0;
				end
			end else if (v_q[N-1] && !res_ready) begin
				skid_full_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_full_q && v_q[N-1] && !res_ready) begin
			skid_q <= last;
		end
	end

	assign res_valid = skid_full_q || v_q[N-1];
	assign res = skid_full_q ? skid_q : last;

endmodule

@@ src/rbi_checker.sv @@
`include "ray_box_intersection_unit_assert.svh"

module rbi_checker (
	input logic clk,
	input logic arst_n,
	input logic ray_valid,
	input logic ray_ready,
	input rbi_pkg::rbi_in_t ray,
	input logic res_valid,
	input logic res_ready,
	input rbi_pkg::rbi_out_t res
);

	`RBI_ASSERT_NEXT(a_ray_hold, ray_valid && !ray_ready, ray_valid && $stable(ray))
	`RBI_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid)
	`RBI_ASSERT_NEXT(a_res_stable, res_valid && !res_ready, $stable(res))
	`RBI_ASSERT_SAME(a_miss_zero, res_valid && !res.hit, {res.point_x, res.point_y, res.point_z} == '0)
	`RBI_ASSERT_SAME(a_stall_cause, !ray_ready, $past(res_valid && !res_ready))

endmodule

bind ray_box_intersection_unit rbi_checker u_rbi_checker (.*);
